// ===== design/dq_pkg.sv =====
// Shared types, sizes and codes for the circular deque.
package dq_pkg;

   // Store size and derived widths
   localparam int DEPTH  = 128;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int OCC_W  = 8;

   // Action codes
   localparam logic [1:0] ACT_PUSH_HEAD = 2'd0;
   localparam logic [1:0] ACT_PUSH_TAIL = 2'd1;
   localparam logic [1:0] ACT_POP_HEAD  = 2'd2;
   localparam logic [1:0] ACT_POP_TAIL  = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Word returned on errors, pushes and for an empty store
   localparam logic signed [WORD_W-1:0] NO_WORD = -32'sd1;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [WORD_W-1:0] value;
   } dq_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped;
      logic [1:0]               status;
      logic signed [WORD_W-1:0] head_value;
      logic signed [WORD_W-1:0] tail_value;
      logic [OCC_W-1:0]         occupancy;
      logic                     is_empty;
      logic                     is_full;
   } dq_rsp_type;

   // Access to the word store for one cycle
   typedef struct packed {
      logic              wr_en;
      logic [PTR_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [PTR_W-1:0]  rd_head_addr;
      logic [PTR_W-1:0]  rd_tail_addr;
   } dq_mem_req_type;

endpackage

// ===== design/circular_deque_top.sv =====
// Circular deque: top level joining the control and the word store.
// A result is valid in the cycle after its request transfer.
// Throughput: one request per cycle; a request transfers while the held
// result is taken in the same cycle, as set by the single result register.
// Reset clears pointers, count and result valid; the store is not cleared
// and needs no clearing pass, since only written slots are ever shown.
module circular_deque_top
   import dq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dq_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dq_rsp_type rsp_data
);

   dq_mem_req_type    mem_req;
   logic [WORD_W-1:0] head_rd;
   logic [WORD_W-1:0] tail_rd;

   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_req   (mem_req),
      .head_rd   (head_rd),
      .tail_rd   (tail_rd)
   );

   dq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .head_rd (head_rd),
      .tail_rd (tail_rd)
   );

endmodule

// ===== design/dq_store.sv =====
// Word store: one write port and two registered read ports.
module dq_store
   import dq_pkg::*;
(
   input  logic                 clock,
   input  dq_mem_req_type       mem_req,
   output logic [WORD_W-1:0]    head_rd,
   output logic [WORD_W-1:0]    tail_rd
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] head_rd_ff;
   logic [WORD_W-1:0] tail_rd_ff;

   // Write the pushed word
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // Read both ends; hold the data between transfers
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         head_rd_ff <= mem[mem_req.rd_head_addr];
         tail_rd_ff <= mem[mem_req.rd_tail_addr];
      end
   end

   assign head_rd = head_rd_ff;
   assign tail_rd = tail_rd_ff;

endmodule

// ===== design/dq_ctrl.sv =====
// Pointer, count and result register control for the circular deque.
module dq_ctrl
   import dq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dq_req_type        req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dq_rsp_type        rsp_data,
   output dq_mem_req_type    mem_req,
   input  logic [WORD_W-1:0] head_rd,
   input  logic [WORD_W-1:0] tail_rd
);

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] popped_ff, popped_in;
   logic [1:0]        status_ff, status_in;
   logic              head_byp_ff, head_byp_in;
   logic              tail_byp_ff, tail_byp_in;
   logic [WORD_W-1:0] push_word_ff;
   logic              accept;
   logic              empty;
   logic              full;
   logic [WORD_W-1:0] cur_head_word;
   logic [WORD_W-1:0] cur_tail_word;
   logic [PTR_W-1:0]  head_inc, head_dec, tail_inc, tail_dec;

   // Hold the input while a waiting result is not taken
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CNT_W'(DEPTH));

   // Words at the ends: freshly pushed word, else registered store data
   assign cur_head_word = head_byp_ff ? push_word_ff : head_rd;
   assign cur_tail_word = tail_byp_ff ? push_word_ff : tail_rd;

   // Wrapping pointer steps
   assign head_inc = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - 1'b1;
   assign tail_inc = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? PTR_W'(DEPTH - 1) : tail_ff - 1'b1;

   // Step the deque for one transfer
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      cnt_in      = cnt_ff;
      popped_in   = NO_WORD;
      status_in   = ST_OK;
      head_byp_in = 1'b0;
      tail_byp_in = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = '0;
      mem_req.wr_data = req_data.value;
      case (req_data.action)
         ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               mem_req.wr_en = accept;
               cnt_in        = cnt_ff + 1'b1;
               if (empty) begin
                  head_in     = '0;
                  tail_in     = '0;
                  head_byp_in = 1'b1;
                  tail_byp_in = 1'b1;
               end else if (req_data.action == ACT_PUSH_HEAD) begin
                  head_in         = head_dec;
                  mem_req.wr_addr = head_dec;
                  head_byp_in     = 1'b1;
               end else begin
                  tail_in         = tail_inc;
                  mem_req.wr_addr = tail_inc;
                  tail_byp_in     = 1'b1;
               end
            end
         end
         ACT_POP_HEAD, ACT_POP_TAIL: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               if (req_data.action == ACT_POP_HEAD) begin
                  popped_in = cur_head_word;
                  head_in   = head_inc;
               end else begin
                  popped_in = cur_tail_word;
                  tail_in   = tail_dec;
               end
               // Drop back to slot zero when the last word leaves
               if (cnt_ff == CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      mem_req.rd_en        = accept;
      mem_req.rd_head_addr = head_in;
      mem_req.rd_tail_addr = tail_in;
   end

   // Result valid: load on transfer, hold while stalled
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         head_byp_ff  <= 1'b0;
         tail_byp_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            cnt_ff      <= cnt_in;
            head_byp_ff <= head_byp_in;
            tail_byp_ff <= tail_byp_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         popped_ff    <= popped_in;
         status_ff    <= status_in;
         push_word_ff <= req_data.value;
      end
   end

   // State only moves on a transfer, so it describes the held result
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data.popped     = popped_ff;
   assign rsp_data.status     = status_ff;
   assign rsp_data.head_value = empty ? NO_WORD : cur_head_word;
   assign rsp_data.tail_value = empty ? NO_WORD : cur_tail_word;
   assign rsp_data.occupancy  = OCC_W'(cnt_ff);
   assign rsp_data.is_empty   = empty;
   assign rsp_data.is_full    = full;

endmodule

// ===== design/dq_checker.sv =====
// Port-level checks for the circular deque, bound to the top level.
module dq_checker
   import dq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input dq_rsp_type rsp_data
);

   // Input stalls only behind a waiting result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a waiting result");

   // Every transfer gives a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("transfer without a following result");

   // Empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.occupancy == '0)))
      else $error("empty flag disagrees with occupancy");

   // A rejected pop leaves an empty deque and no word
   a_empty_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_EMPTY) |->
         (rsp_data.is_empty && rsp_data.popped == NO_WORD))
      else $error("rejected pop on a non-empty deque");

   // Full flag agrees with the count
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_full == (rsp_data.occupancy == OCC_W'(DEPTH))))
      else $error("full flag disagrees with occupancy");

endmodule

bind circular_deque_top dq_checker u_dq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
